>>> hdl/fbpa_pkg.sv
// ============================================================================
// fbpa_pkg
// Shared types, codes and stream layout for the fixed block pool allocator.
// ============================================================================
`default_nettype none

package fbpa_pkg;

    // Pool geometry defaults
    localparam int POOL_DEPTH_DEF = 256;
    localparam int POOL_RST       = 256;

    // Register widths and reset values
    localparam int        BLK_SIZE_W   = 17;
    localparam int        POOL_REG_W   = 9;
    localparam logic [16:0] BLK_SIZE_RST = 17'd2048;

    // Field widths
    localparam int REL_W    = 8;
    localparam int BLK_W    = 8;
    localparam int OFF_W    = 24;
    localparam int CNT_OUT_W = 9;
    localparam int FAIL_W   = 32;

    localparam logic [OFF_W-1:0]  OFFSET_MAX = 24'hFF_FFFF;
    localparam logic [FAIL_W-1:0] FAIL_MAX   = 32'hFFFF_FFFF;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Result tdata layout, lowest bit first
    localparam int OUT_BLK_LO  = 0;
    localparam int OUT_OFF_LO  = OUT_BLK_LO + BLK_W;
    localparam int OUT_FREE_LO = OUT_OFF_LO + OFF_W;
    localparam int OUT_USED_LO = OUT_FREE_LO + CNT_OUT_W;
    localparam int OUT_PEAK_LO = OUT_USED_LO + CNT_OUT_W;
    localparam int OUT_FAIL_LO = OUT_PEAK_LO + CNT_OUT_W;
    localparam int OUT_BITS    = OUT_FAIL_LO + FAIL_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [0:0] {
        REG_BLOCK_SIZE = 1'b0,
        REG_POOL_SIZE  = 1'b1
    } t_reg;

    typedef enum logic [0:0] {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STS_GRANTED  = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_RELEASED = 2'd2,
        STS_IGNORED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } t_state;

endpackage

`default_nettype wire

>>> hdl/fixed_block_pool_allocator_core.sv
// ============================================================================
// fixed_block_pool_allocator_core
// Free-index stack allocator for a pool of equal-size blocks, with busy marks,
// in-use statistics and a saturating failure count.
// ============================================================================
// Flow: a request accepted in IDLE executes in EXEC, then moves through the
//   middle stage into the output register once that register is free.
// Issue: s_axis_tready is low in EXEC, as the read and write-back of the
//   free-stack and busy-mark memories (one port pair each) span IDLE and EXEC.
// Reset: synchronous, active low. After reset, and after every pool-size write,
//   a clearing pass over all POOL_DEPTH entries zeroes the busy marks;
//   s_axis_tready stays low until it ends. Configuration writes are taken throughout.
`default_nettype none

module fixed_block_pool_allocator_core #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Request stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [fbpa_pkg::REL_W-1:0]         s_axis_tdata,   // [7:0] release_block
    input  wire logic                               s_axis_tuser,   // [0] operation
    // Result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [7:0] granted_block, [31:8] granted_offset, [40:32] free_count,
    // [49:41] used_count, [58:50] peak_used, [90:59] failures, [95:91] zero
    output logic [fbpa_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic [1:0]                              m_axis_tuser,   // [1:0] status
    // Configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [fbpa_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [fbpa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fbpa_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int IDX_W  = $clog2(POOL_DEPTH);
    localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > fbpa_pkg::POOL_REG_W) ? CNT_W : fbpa_pkg::POOL_REG_W;
    localparam int PROD_W = IDX_W + fbpa_pkg::BLK_SIZE_W;
    localparam int MUL_W  = (PROD_W > fbpa_pkg::OFF_W) ? PROD_W : fbpa_pkg::OFF_W + 1;
    localparam int N_RST  = (POOL_DEPTH < fbpa_pkg::POOL_RST) ? POOL_DEPTH : fbpa_pkg::POOL_RST;
    localparam int PAD_W  = fbpa_pkg::OUT_TDATA_W - fbpa_pkg::OUT_BITS;

    // ------------------------------------------------------------------
    // Memories: free-index stack and busy marks
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] stack_mem [POOL_DEPTH];
    logic             busy_mem  [POOL_DEPTH];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    fbpa_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0]               r_clr;
    logic [fbpa_pkg::BLK_SIZE_W-1:0] r_blk_size;
    logic [CNT_W-1:0]               r_n, r_top, n_top, r_low, n_low, r_peak, n_peak;
    logic [fbpa_pkg::FAIL_W-1:0]    r_fail, n_fail;
    logic                           r_op;
    logic [fbpa_pkg::REL_W-1:0]     r_rel;
    logic [IDX_W-1:0]               r_stk_q;
    logic                           r_busy_q;

    // Result staging: a middle stage ahead of the multiplier, then the output
    logic                           r_mid_vld;
    fbpa_pkg::t_status              r_mid_sts, n_mid_sts;
    logic [IDX_W-1:0]               r_mid_blk, n_mid_blk;
    logic [fbpa_pkg::CNT_OUT_W-1:0] r_mid_free, r_mid_used, r_mid_peak;
    logic [fbpa_pkg::FAIL_W-1:0]    r_mid_fail;

    logic                           r_out_vld;
    fbpa_pkg::t_status              r_out_sts;
    logic [fbpa_pkg::BLK_W-1:0]     r_out_blk;
    logic [fbpa_pkg::OFF_W-1:0]     r_out_off;
    logic [fbpa_pkg::CNT_OUT_W-1:0] r_out_free, r_out_used, r_out_peak;
    logic [fbpa_pkg::FAIL_W-1:0]    r_out_fail;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic             cfg_wr;
    logic             cfg_pool_wr;
    logic [CMP_W-1:0] pool_req;
    logic [CNT_W-1:0] pool_new;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign cfg_pool_wr = cfg_wr && (paddr[2] == fbpa_pkg::REG_POOL_SIZE);

    // Clamp the requested pool size into 1..POOL_DEPTH
    always_comb begin
        pool_req = CMP_W'(pwdata[fbpa_pkg::POOL_REG_W-1:0]);
        if (pool_req == '0) begin
            pool_new = CNT_W'(1);
        end else if (pool_req > CMP_W'(POOL_DEPTH)) begin
            pool_new = CNT_W'(POOL_DEPTH);
        end else begin
            pool_new = pool_req[CNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == fbpa_pkg::REG_POOL_SIZE) begin
            prdata = fbpa_pkg::APB_DATA_W'(r_n);
        end else begin
            prdata = fbpa_pkg::APB_DATA_W'(r_blk_size);
        end
    end

    // ------------------------------------------------------------------
    // Control FSM
    // ------------------------------------------------------------------
    logic mid_adv;
    logic acc;
    logic clr_en;
    logic exec_en;

    // Middle stage moves on whenever the output register is free or drained
    assign mid_adv = r_mid_vld && (!r_out_vld || m_axis_tready);
    assign acc     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            fbpa_pkg::S_CLEAR: begin
                if (r_clr == IDX_W'(POOL_DEPTH - 1)) begin
                    n_state = fbpa_pkg::S_IDLE;
                end
            end
            fbpa_pkg::S_IDLE: begin
                if (acc) begin
                    n_state = fbpa_pkg::S_EXEC;
                end
            end
            fbpa_pkg::S_EXEC: begin
                n_state = fbpa_pkg::S_IDLE;
            end
            default: begin
                n_state = fbpa_pkg::S_CLEAR;
            end
        endcase
        // A new pool size restarts the clearing pass
        if (cfg_pool_wr) begin
            n_state = fbpa_pkg::S_CLEAR;
        end
    end

    always_comb begin
        s_axis_tready = 1'b0;
        clr_en        = 1'b0;
        exec_en       = 1'b0;
        case (r_state)
            fbpa_pkg::S_CLEAR: begin
                clr_en = 1'b1;
            end
            fbpa_pkg::S_IDLE: begin
                s_axis_tready = !r_mid_vld || mid_adv;
            end
            fbpa_pkg::S_EXEC: begin
                exec_en = 1'b1;
            end
            default: begin
                clr_en = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Memory read addresses (issued on accept)
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] top_m1;
    logic [CMP_W-1:0] in_rel_w;
    logic [CMP_W-1:0] rel_w;
    logic [IDX_W-1:0] rel_idx;

    assign top_m1   = r_top - CNT_W'(1);
    assign in_rel_w = CMP_W'(s_axis_tdata);
    assign rel_w    = CMP_W'(r_rel);
    assign rel_idx  = rel_w[IDX_W-1:0];

    // ------------------------------------------------------------------
    // Execute: read-modify-write on stack and marks
    // ------------------------------------------------------------------
    logic             virgin;
    logic [CNT_W-1:0] virgin_val;
    logic [IDX_W-1:0] pop_blk;
    logic             rel_ok;
    logic [CNT_W-1:0] used_new;
    logic             stk_we;
    logic             busy_we;
    logic [IDX_W-1:0] busy_waddr;
    logic             busy_wdata;

    // Entries below the low-water mark were never written since init:
    // they count as holding their initial value n-1-pos, computed here.
    assign virgin     = top_m1 < r_low;
    assign virgin_val = r_n - CNT_W'(1) - top_m1;
    assign pop_blk    = virgin ? virgin_val[IDX_W-1:0] : r_stk_q;
    assign rel_ok     = (rel_w < CMP_W'(r_n)) && r_busy_q && (r_top < CNT_W'(POOL_DEPTH));

    always_comb begin
        n_top      = r_top;
        n_low      = r_low;
        n_peak     = r_peak;
        n_fail     = r_fail;
        n_mid_sts  = fbpa_pkg::STS_IGNORED;
        n_mid_blk  = '0;
        used_new   = r_n - r_top;
        stk_we     = 1'b0;
        busy_we    = 1'b0;
        busy_waddr = r_clr;
        busy_wdata = 1'b0;
        if (clr_en) begin
            busy_we = 1'b1;
        end else if (exec_en) begin
            if (r_op == fbpa_pkg::OP_ACQUIRE) begin
                if (r_top == '0) begin
                    n_mid_sts = fbpa_pkg::STS_EMPTY;
                    if (r_fail != fbpa_pkg::FAIL_MAX) begin
                        n_fail = r_fail + fbpa_pkg::FAIL_W'(1);
                    end
                end else begin
                    n_mid_sts  = fbpa_pkg::STS_GRANTED;
                    n_mid_blk  = pop_blk;
                    n_top      = top_m1;
                    busy_we    = 1'b1;
                    busy_waddr = pop_blk;
                    busy_wdata = 1'b1;
                    used_new   = r_n - top_m1;
                    if (top_m1 < r_low) begin
                        n_low = top_m1;
                    end
                    if (used_new > r_peak) begin
                        n_peak = used_new;
                    end
                end
            end else begin
                if (rel_ok) begin
                    n_mid_sts  = fbpa_pkg::STS_RELEASED;
                    n_top      = r_top + CNT_W'(1);
                    used_new   = r_n - n_top;
                    stk_we     = 1'b1;
                    busy_we    = 1'b1;
                    busy_waddr = rel_idx;
                    busy_wdata = 1'b0;
                end
            end
        end
    end

    // Memory ports: registered reads, single write each
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_stk_q  <= stack_mem[top_m1[IDX_W-1:0]];
            r_busy_q <= busy_mem[in_rel_w[IDX_W-1:0]];
        end
        if (stk_we) begin
            stack_mem[r_top[IDX_W-1:0]] <= rel_idx;
        end
        if (busy_we) begin
            busy_mem[busy_waddr] <= busy_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Control and statistics registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fbpa_pkg::S_CLEAR;
            r_clr      <= '0;
            r_blk_size <= fbpa_pkg::BLK_SIZE_RST;
            r_n        <= CNT_W'(N_RST);
            r_top      <= CNT_W'(N_RST);
            r_low      <= CNT_W'(N_RST);
            r_peak     <= '0;
            r_fail     <= '0;
            r_mid_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_pool_wr) begin
                r_clr <= '0;
            end else if (clr_en) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (cfg_wr && (paddr[2] == fbpa_pkg::REG_BLOCK_SIZE)) begin
                r_blk_size <= pwdata[fbpa_pkg::BLK_SIZE_W-1:0];
            end
            // Re-initialise the pool on a size write
            if (cfg_pool_wr) begin
                r_n    <= pool_new;
                r_top  <= pool_new;
                r_low  <= pool_new;
                r_peak <= '0;
                r_fail <= '0;
            end else begin
                r_top  <= n_top;
                r_low  <= n_low;
                r_peak <= n_peak;
                r_fail <= n_fail;
            end
            if (exec_en) begin
                r_mid_vld <= 1'b1;
            end else if (mid_adv) begin
                r_mid_vld <= 1'b0;
            end
            if (mid_adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op  <= s_axis_tuser;
            r_rel <= s_axis_tdata;
        end
    end

    // Middle stage: hold post-step counts and the granted index
    always_ff @(posedge i_clk) begin
        if (exec_en) begin
            r_mid_sts  <= n_mid_sts;
            r_mid_blk  <= n_mid_blk;
            r_mid_free <= fbpa_pkg::CNT_OUT_W'(n_top);
            r_mid_used <= fbpa_pkg::CNT_OUT_W'(used_new);
            r_mid_peak <= fbpa_pkg::CNT_OUT_W'(n_peak);
            r_mid_fail <= n_fail;
        end
    end

    // ------------------------------------------------------------------
    // Offset multiply and saturate into the output register
    // ------------------------------------------------------------------
    logic [MUL_W-1:0] prod;

    assign prod = MUL_W'(r_mid_blk) * MUL_W'(r_blk_size);

    always_ff @(posedge i_clk) begin
        if (mid_adv) begin
            r_out_sts  <= r_mid_sts;
            r_out_blk  <= fbpa_pkg::BLK_W'(r_mid_blk);
            if (prod > MUL_W'(fbpa_pkg::OFFSET_MAX)) begin
                r_out_off <= fbpa_pkg::OFFSET_MAX;
            end else begin
                r_out_off <= prod[fbpa_pkg::OFF_W-1:0];
            end
            r_out_free <= r_mid_free;
            r_out_used <= r_mid_used;
            r_out_peak <= r_mid_peak;
            r_out_fail <= r_mid_fail;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_sts;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_fail, r_out_peak, r_out_used,
                            r_out_free, r_out_off, r_out_blk};

endmodule

`default_nettype wire

>>> hdl/fbpa_checker.sv
// ============================================================================
// fbpa_checker
// Port-level assertions for the fixed block pool allocator, bound to the core.
// ============================================================================
`default_nettype none

module fbpa_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [fbpa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic [1:0]                         m_axis_tuser,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [fbpa_pkg::APB_ADDR_W-1:0]    paddr
);

    logic [fbpa_pkg::BLK_W-1:0]     blk;
    logic [fbpa_pkg::OFF_W-1:0]     off;
    logic [fbpa_pkg::CNT_OUT_W-1:0] used;
    logic [fbpa_pkg::CNT_OUT_W-1:0] peak;

    assign blk  = m_axis_tdata[fbpa_pkg::OUT_BLK_LO  +: fbpa_pkg::BLK_W];
    assign off  = m_axis_tdata[fbpa_pkg::OUT_OFF_LO  +: fbpa_pkg::OFF_W];
    assign used = m_axis_tdata[fbpa_pkg::OUT_USED_LO +: fbpa_pkg::CNT_OUT_W];
    assign peak = m_axis_tdata[fbpa_pkg::OUT_PEAK_LO +: fbpa_pkg::CNT_OUT_W];

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // One request at a time: ready drops after each accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted back to back");

    // Pool-size write starts the clearing pass
    a_pool_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == fbpa_pkg::REG_POOL_SIZE) |=>
            !s_axis_tready)
        else $error("requests taken right after pool re-initialisation");

    // Non-granted results carry no block or offset
    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != fbpa_pkg::STS_GRANTED) |->
            (blk == '0) && (off == '0))
        else $error("block or offset set on a non-granted result");

    // High-water mark never below the in-use count
    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> used <= peak)
        else $error("in-use count above high-water mark");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (.*);

`default_nettype wire
